>>> sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int unsigned MAX_POINTS_DEF = 256;
    localparam int unsigned QUEUE_DEPTH    = 2;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_SINGLE = 3'd1,
        STS_EMPTY  = 3'd2,
        STS_ZERO_W = 3'd3,
        STS_SAT    = 3'd4
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic               first_item;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_y;
        logic [2:0]         status;
    } t_out_item;

    typedef struct packed {
        t_req               kind;
        logic               first;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
    } t_q_item;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ONE_W,
        BK_ONE_C,
        BK_WALK_W,
        BK_WALK_C,
        BK_HI_W,
        BK_HI_C,
        BK_LO_W,
        BK_LO_C,
        BK_MUL,
        BK_DIV,
        BK_FIN,
        BK_OUT
    } t_back_state;

endpackage

>>> sv/pli_front.sv
// ----------------------------------------------------------------------------
// pli_front
// Accepts items, classifies them as load or query and queues them.
// ----------------------------------------------------------------------------
module pli_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pli_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output logic              o_q_valid,
    output pli_pkg::t_q_item  o_q_item,
    input  logic              i_q_pop
);

    localparam int unsigned PW = $clog2(pli_pkg::QUEUE_DEPTH);

    pli_pkg::t_q_item r_mem [pli_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW:0]      r_cnt, n_cnt;
    pli_pkg::t_q_item w_cls;
    logic             w_push;

    always_comb begin
        w_cls.kind  = i_in_item.req_type ? pli_pkg::REQ_QUERY : pli_pkg::REQ_LOAD;
        w_cls.first = i_in_item.first_item;
        w_cls.val_x = i_in_item.req_type ? i_in_item.query_x : i_in_item.point_x;
        w_cls.val_y = i_in_item.point_y;
    end

    assign o_in_stall = (r_cnt == (PW+1)'(pli_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rp];

    always_comb begin
        n_wp  = w_push ? PW'(r_wp + 1'b1) : r_wp;
        n_rp  = i_q_pop ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + (PW+1)'(w_push) - (PW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cls;
        end
    end

endmodule

>>> sv/pli_back.sv
// ----------------------------------------------------------------------------
// pli_back
// Table store, segment walk, serial multiply and divide, result register.
// ----------------------------------------------------------------------------
module pli_back #(
    parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pli_pkg::t_q_item   i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output pli_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = AW + 1;

    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];

    pli_pkg::t_back_state r_st, n_st;
    logic [CW-1:0]      r_pl, n_pl;
    logic [AW-1:0]      r_wi, n_wi;
    logic [AW-1:0]      r_j, n_j;
    logic [AW-1:0]      r_addr, n_addr;
    logic signed [31:0] r_rd_x, r_rd_y;
    logic signed [31:0] r_q, n_q;
    logic signed [31:0] r_x1, n_x1;
    logic signed [31:0] r_y1, n_y1;
    logic signed [31:0] r_y0, n_y0;
    logic [31:0]        r_mdx, n_mdx;
    logic [31:0]        r_mc, n_mc;
    logic [63:0]        r_prod, n_prod;
    logic [31:0]        r_rem, n_rem;
    logic               r_neg, n_neg;
    logic [5:0]         r_cnt, n_cnt;
    logic signed [31:0] r_res_y, n_res_y;
    pli_pkg::t_status   r_res_s, n_res_s;
    logic               r_ov, n_ov;
    pli_pkg::t_out_item r_out, n_out;

    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [CW-1:0]      w_pm1;
    logic [AW-1:0]      w_j0;
    logic               w_adv;
    logic [AW-1:0]      w_jj;
    logic signed [32:0] w_dx, w_dy, w_dq;
    logic [32:0]        w_msum;
    logic [32:0]        w_dsh;
    logic               w_dge;
    logic               w_rnd;
    logic [64:0]        w_quo;
    logic signed [35:0] w_r;
    logic               w_out_free;

    assign w_pm1      = r_pl - 1'b1;
    assign w_j0       = (CW'(r_wi) > w_pm1) ? w_pm1[AW-1:0] : r_wi;
    assign w_adv      = (CW'(r_j) < w_pm1) && (r_rd_x < r_q);
    assign w_jj       = (r_j == '0) ? AW'(1) : r_j;
    assign w_dx       = 33'(r_x1) - 33'(r_rd_x);
    assign w_dy       = 33'(r_y1) - 33'(r_rd_y);
    assign w_dq       = 33'(r_q) - 33'(r_rd_x);
    assign w_msum     = {1'b0, r_prod[63:32]} + (r_prod[0] ? {1'b0, r_mc} : 33'd0);
    assign w_dsh      = {r_rem, r_prod[63]};
    assign w_dge      = w_dsh >= {1'b0, r_mdx};
    assign w_rnd      = {r_rem, 1'b0} >= {1'b0, r_mdx};
    assign w_quo      = {1'b0, r_prod} + 65'(w_rnd);
    assign w_r        = r_neg ? (36'(r_y0) - $signed({1'b0, w_quo[34:0]}))
                              : (36'(r_y0) + $signed({1'b0, w_quo[34:0]}));
    assign w_out_free = !r_ov || !i_out_stall;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            pli_pkg::BK_IDLE: begin
                if (i_q_valid && i_q_item.kind == pli_pkg::REQ_QUERY) begin
                    if (r_pl == '0) begin
                        n_st = pli_pkg::BK_OUT;
                    end else if (r_pl == CW'(1)) begin
                        n_st = pli_pkg::BK_ONE_W;
                    end else begin
                        n_st = pli_pkg::BK_WALK_W;
                    end
                end
            end
            pli_pkg::BK_ONE_W:  n_st = pli_pkg::BK_ONE_C;
            pli_pkg::BK_ONE_C:  n_st = pli_pkg::BK_OUT;
            pli_pkg::BK_WALK_W: n_st = pli_pkg::BK_WALK_C;
            pli_pkg::BK_WALK_C: begin
                if (w_adv) begin
                    n_st = pli_pkg::BK_WALK_W;
                end else if (r_rd_x == r_q) begin
                    n_st = pli_pkg::BK_OUT;
                end else begin
                    n_st = pli_pkg::BK_HI_W;
                end
            end
            pli_pkg::BK_HI_W:   n_st = pli_pkg::BK_HI_C;
            pli_pkg::BK_HI_C:   n_st = pli_pkg::BK_LO_W;
            pli_pkg::BK_LO_W:   n_st = pli_pkg::BK_LO_C;
            pli_pkg::BK_LO_C:   n_st = (w_dx == '0) ? pli_pkg::BK_OUT : pli_pkg::BK_MUL;
            pli_pkg::BK_MUL:    n_st = (r_cnt == 6'd31) ? pli_pkg::BK_DIV : pli_pkg::BK_MUL;
            pli_pkg::BK_DIV:    n_st = (r_cnt == 6'd63) ? pli_pkg::BK_FIN : pli_pkg::BK_DIV;
            pli_pkg::BK_FIN:    n_st = pli_pkg::BK_OUT;
            pli_pkg::BK_OUT:    n_st = w_out_free ? pli_pkg::BK_IDLE : pli_pkg::BK_OUT;
            default:            n_st = pli_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_q_pop = 1'b0;
        w_we    = 1'b0;
        w_wa    = r_pl[AW-1:0];
        n_pl    = r_pl;
        n_wi    = r_wi;
        n_j     = r_j;
        n_addr  = r_addr;
        n_q     = r_q;
        n_x1    = r_x1;
        n_y1    = r_y1;
        n_y0    = r_y0;
        n_mdx   = r_mdx;
        n_mc    = r_mc;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_res_y = r_res_y;
        n_res_s = r_res_s;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        case (r_st)
            pli_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.kind == pli_pkg::REQ_LOAD) begin
                        if (i_q_item.first) begin
                            w_we = 1'b1;
                            w_wa = '0;
                            n_pl = CW'(1);
                            n_wi = '0;
                        end else if (r_pl < CW'(MAX_POINTS)) begin
                            w_we = 1'b1;
                            n_pl = r_pl + 1'b1;
                        end
                    end else begin
                        n_q = i_q_item.val_x;
                        if (i_q_item.first) begin
                            n_wi = '0;
                        end
                        if (r_pl == '0) begin
                            n_res_y = '0;
                            n_res_s = pli_pkg::STS_EMPTY;
                        end else if (r_pl == CW'(1)) begin
                            n_addr = '0;
                        end else begin
                            n_j    = i_q_item.first ? '0 : w_j0;
                            n_addr = i_q_item.first ? '0 : w_j0;
                        end
                    end
                end
            end
            pli_pkg::BK_ONE_C: begin
                n_res_y = r_rd_y;
                n_res_s = pli_pkg::STS_SINGLE;
            end
            pli_pkg::BK_WALK_C: begin
                if (w_adv) begin
                    n_j    = r_j + 1'b1;
                    n_addr = r_j + 1'b1;
                end else begin
                    n_wi = r_j;
                    if (r_rd_x == r_q) begin
                        n_res_y = r_rd_y;
                        n_res_s = pli_pkg::STS_OK;
                    end else begin
                        n_addr = w_jj;
                    end
                end
            end
            pli_pkg::BK_HI_C: begin
                n_x1   = r_rd_x;
                n_y1   = r_rd_y;
                n_addr = r_addr - 1'b1;
            end
            pli_pkg::BK_LO_C: begin
                n_y0    = r_rd_y;
                n_res_y = r_rd_y;
                n_res_s = pli_pkg::STS_ZERO_W;
                n_mdx   = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
                n_mc    = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
                n_prod  = {32'd0, (w_dq[32] ? 32'(-w_dq) : w_dq[31:0])};
                n_neg   = (w_dy[32] ^ w_dq[32]) ^ w_dx[32];
                n_cnt   = '0;
            end
            pli_pkg::BK_MUL: begin
                n_prod = {w_msum, r_prod[31:1]};
                n_cnt  = (r_cnt == 6'd31) ? 6'd0 : r_cnt + 1'b1;
                n_rem  = '0;
            end
            pli_pkg::BK_DIV: begin
                n_rem  = w_dge ? 32'(w_dsh - {1'b0, r_mdx}) : w_dsh[31:0];
                n_prod = {r_prod[62:0], w_dge};
                n_cnt  = r_cnt + 1'b1;
            end
            pli_pkg::BK_FIN: begin
                if (w_quo > 65'h2_0000_0000) begin
                    n_res_y = r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    n_res_s = pli_pkg::STS_SAT;
                end else if (w_r > 36'sh0_7fff_ffff) begin
                    n_res_y = 32'sh7fff_ffff;
                    n_res_s = pli_pkg::STS_SAT;
                end else if (w_r < -36'sh0_8000_0000) begin
                    n_res_y = 32'sh8000_0000;
                    n_res_s = pli_pkg::STS_SAT;
                end else begin
                    n_res_y = w_r[31:0];
                    n_res_s = pli_pkg::STS_OK;
                end
            end
            pli_pkg::BK_OUT: begin
                if (w_out_free) begin
                    n_ov         = 1'b1;
                    n_out.out_y  = r_res_y;
                    n_out.status = r_res_s;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pli_pkg::BK_IDLE;
            r_pl <= '0;
            r_wi <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pl <= n_pl;
            r_wi <= n_wi;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_addr  <= n_addr;
        r_q     <= n_q;
        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_y0    <= n_y0;
        r_mdx   <= n_mdx;
        r_mc    <= n_mc;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_res_y <= n_res_y;
        r_res_s <= n_res_s;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[w_wa] <= i_q_item.val_x;
            mem_y[w_wa] <= i_q_item.val_y;
        end
        r_rd_x <= mem_x[r_addr];
        r_rd_y <= mem_y[r_addr];
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

>>> sv/piecewise_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Piecewise linear interpolation over a loaded table of signed Q16.16 points.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_item) takes load items, which
// store one table point each, and query items, which produce one result each.
// Output channel (o_out_valid / i_out_stall / o_out_item) carries out_y and
// status for every query, in query order. Loads produce nothing.
// A two-entry queue sits between the input side and the execution engine, so
// items are taken while a query is still being worked on.
// A load writes one table entry. A query on an empty table goes straight to
// the result, and one on a one-point table reads that point. Other queries
// walk the table one entry at a time; an exact match on x returns that y,
// else the two points around the query are read and a serial shift-add
// multiply and a restoring divide follow. The table has one write port and
// one read port, and its read data is registered.
// Reset (synchronous, active low) empties the table and the queue and drops
// the output valid; table contents are not cleared.
// While i_out_stall is high the result holds and the engine waits on it; the
// queue keeps accepting items until full, then o_in_stall rises.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core #(
    parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pli_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pli_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic             w_q_valid;
    logic             w_q_pop;
    pli_pkg::t_q_item w_q_item;

    pli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    pli_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> sv/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
module pli_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input pli_pkg::t_in_item  i_in_item,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input pli_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= pli_pkg::STS_SAT))
        else $error("status code out of range");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == pli_pkg::STS_SAT) |->
        (o_out_item.out_y == 32'sh7fff_ffff || o_out_item.out_y == 32'sh8000_0000))
        else $error("saturated result not at a limit");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == pli_pkg::STS_EMPTY) |->
        (o_out_item.out_y == '0))
        else $error("empty table result not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
